### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertions shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same, for the usual clock and reset names
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/core/dpb_pkg.sv
// ----------------------------------------------------------------------------
// dpb_pkg
// shared types and constants of the depth pixel back-projection block
// ----------------------------------------------------------------------------
package dpb_pkg;

  localparam int unsigned NumStages = 4;

  localparam int unsigned DepthW  = 16;
  localparam int unsigned PixW    = 12;
  localparam int unsigned CenterW = 16;
  localparam int unsigned RecipW  = 24;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned DepthRot = 3;
  localparam int unsigned FracShift = 24;
  localparam int unsigned ZdW   = DepthW + CenterW;
  localparam int unsigned ProdW = ZdW + RecipW;

  localparam logic [CfgIdxW-1:0] RegCenterX = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCenterY = 2'd1;
  localparam logic [CfgIdxW-1:0] RegInvFx   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegInvFy   = 2'd3;

  localparam logic [CenterW-1:0] CenterXRst = 16'd5071;
  localparam logic [CenterW-1:0] CenterYRst = 16'd3909;
  localparam logic [RecipW-1:0]  InvFxRst   = 24'd29280;
  localparam logic [RecipW-1:0]  InvFyRst   = 24'd29537;

  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] vld;
  } pipe_ctrl_t;

endpackage

### rtl/core/dpb_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// dpb_pipe_ctrl
// valid bits and per-stage load enables; stages with bubbles keep filling
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpb_pipe_ctrl
  import dpb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output pipe_ctrl_t ctrl_o
);

  logic [NumStages-1:0] vld_q, vld_d, en;

  always_comb begin
    en[NumStages-1] = ~vld_q[NumStages-1] | out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    for (int k = 0; k < NumStages; k++) begin
      if (en[k]) begin
        vld_d[k] = (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o = en[0];
  assign ctrl_o.en  = en;
  assign ctrl_o.vld = vld_q;

  `ASSERT_STD(a_fire_fills, in_valid_i && in_ready_o |=> vld_q[0], "accepted word lost")
  `ASSERT_STD(a_full_stall, (&vld_q) && !out_ready_i |-> !in_ready_o, "accept while full")
  `ASSERT_STD(a_hold_word, vld_q[NumStages-1] && !out_ready_i |=> vld_q[NumStages-1],
              "stalled word dropped")

endmodule

### rtl/core/dpb_axis.sv
// ----------------------------------------------------------------------------
// dpb_axis
// one coordinate: offset, depth product, reciprocal product, round and saturate
// ----------------------------------------------------------------------------
module dpb_axis
  import dpb_pkg::*;
(
  input  logic                     clk_i,
  input  pipe_ctrl_t               ctrl_i,
  input  logic [PixW-1:0]          pix_i,
  input  logic [CenterW-1:0]       center_i,
  input  logic [RecipW-1:0]        recip_i,
  input  logic [DepthW-1:0]        z_s1_i,
  output logic signed [CoordW-1:0] coord_o
);

  logic [CenterW:0]   diff;
  logic               neg1_q, neg2_q, neg3_q;
  logic [CenterW-1:0] dmag_q, dmag_d;
  logic [ZdW-1:0]     zd_q;
  logic [ProdW-1:0]   prod_q;
  logic [ProdW:0]     rnd;
  logic [CoordW:0]    mag;
  logic [CoordW-1:0]  coord_d;
  logic signed [CoordW-1:0] coord_q;

  assign diff   = {1'b0, pix_i, 4'b0000} - {1'b0, center_i};
  assign dmag_d = diff[CenterW] ? CenterW'(-diff) : diff[CenterW-1:0];

  assign rnd = {1'b0, prod_q} + ((ProdW + 1)'(1) << (FracShift - 1));
  assign mag = rnd[ProdW:FracShift];

  always_comb begin
    if (neg3_q) begin
      coord_d = (mag[CoordW:CoordW-1] != 2'b00) ? {1'b1, {(CoordW-1){1'b0}}}
                                                : CoordW'(-mag);
    end else begin
      coord_d = (mag[CoordW:CoordW-1] != 2'b00) ? {1'b0, {(CoordW-1){1'b1}}}
                                                : mag[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      neg1_q <= diff[CenterW];
      dmag_q <= dmag_d;
    end
    if (ctrl_i.en[1]) begin
      neg2_q <= neg1_q;
      zd_q   <= z_s1_i * dmag_q;
    end
    if (ctrl_i.en[2]) begin
      neg3_q <= neg2_q;
      prod_q <= zd_q * recip_i;
    end
    if (ctrl_i.en[3]) begin
      coord_q <= coord_d;
    end
  end

  assign coord_o = coord_q;

endmodule

### rtl/core/depth_pixel_backprojection_top.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_top
// back-projects raw depth pixels to camera points through a pinhole model
// ----------------------------------------------------------------------------
// usage
//   s_axis: one word per pixel, raw depth word, column and row
//   m_axis: one word per pixel, point x, y (mm, 4 fraction bits), depth z;
//           tuser is set when the depth is nonzero
//   cfg: write enable, index and data; center x, center y, 1/fx, 1/fy
//   output valid is set while the pixel sits in the last stage, and one pixel
//   is taken every cycle unless a full pipeline is stalled; the 4 register
//   stages are offset, depth times offset, times reciprocal, round and saturate
//   stages load independently, so empty stages still fill while the output
//   word waits; with all 4 stages full and m_axis_tready low, s_axis_tready
//   drops and every word holds its place
//   reset empties the pipeline and loads the default camera constants
//   write configuration only while no pixel is in flight
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module depth_pixel_backprojection_top
  import dpb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,   // raw_depth, column, row
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [79:0]         m_axis_tdata,   // point_x, point_y, point_z
  output logic                m_axis_tuser,   // has_depth
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [CenterW-1:0] center_x_q, center_y_q;
  logic [RecipW-1:0]  inv_fx_q, inv_fy_q;
  pipe_ctrl_t         ctrl;

  logic [DepthW-1:0] raw_depth, z_in;
  logic [PixW-1:0]   column, row;
  logic [DepthW-1:0] z_q [NumStages];
  logic signed [CoordW-1:0] point_x, point_y;

  assign raw_depth = s_axis_tdata[15:0];
  assign column    = s_axis_tdata[27:16];
  assign row       = s_axis_tdata[39:28];
  assign z_in      = {raw_depth[DepthRot-1:0], raw_depth[DepthW-1:DepthRot]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= CenterXRst;
      center_y_q <= CenterYRst;
      inv_fx_q   <= InvFxRst;
      inv_fy_q   <= InvFyRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCenterX: center_x_q <= cfg_data_i[CenterW-1:0];
        RegCenterY: center_y_q <= cfg_data_i[CenterW-1:0];
        RegInvFx:   inv_fx_q   <= cfg_data_i;
        RegInvFy:   inv_fy_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dpb_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl)
  );

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (ctrl.en[k]) begin
        z_q[k] <= (k == 0) ? z_in : z_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  dpb_axis u_axis_x (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .pix_i    (column),
    .center_i (center_x_q),
    .recip_i  (inv_fx_q),
    .z_s1_i   (z_q[0]),
    .coord_o  (point_x)
  );

  dpb_axis u_axis_y (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .pix_i    (row),
    .center_i (center_y_q),
    .recip_i  (inv_fy_q),
    .z_s1_i   (z_q[0]),
    .coord_o  (point_y)
  );

  assign m_axis_tvalid = ctrl.vld[NumStages-1];
  assign m_axis_tdata  = {z_q[NumStages-1], point_y, point_x};
  assign m_axis_tuser  = (z_q[NumStages-1] != '0);

  `ASSERT_STD(a_no_depth_zero, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0,
              "zero depth gives a nonzero point")
  `ASSERT_STD(a_cfg_cx, cfg_we_i && cfg_idx_i == RegCenterX |=>
              center_x_q == $past(cfg_data_i[CenterW-1:0]), "center x write lost")
  `ASSERT_STD(a_cfg_fy, cfg_we_i && cfg_idx_i == RegInvFy |=>
              inv_fy_q == $past(cfg_data_i), "inverse focal y write lost")

endmodule
